### rtl/esdt_pkg.sv
package esdt_pkg;

  // Field widths
  localparam int unsigned SECS_W  = 32;
  localparam int unsigned DAYS_W  = 16;
  localparam int unsigned SOD_W   = 17;
  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DOM_W   = 5;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned SEC_W   = 6;
  localparam int unsigned WDAY_W  = 3;

  // Internal widths
  localparam int unsigned Z_W     = 20;  // day number from 0000-03-01
  localparam int unsigned DOE_W   = 18;  // day of era
  localparam int unsigned YOE_W   = 9;   // year of era
  localparam int unsigned DOY_W   = 9;   // day of March-based year
  localparam int unsigned MP_W    = 4;   // March-based month

  // 86400 = 675 << 7; quotient by 675 via reciprocal 2^25/675
  localparam int unsigned DAY_SH       = 7;
  localparam int unsigned DAY_DIV      = 675;
  localparam int unsigned DAY_RECIP    = 49710;
  localparam int unsigned DAY_RECIP_SH = 25;

  // Day number offsets
  localparam int unsigned Z_OFFSET   = 730425;  // 2000-01-01 counted from 0000-03-01
  localparam int unsigned ERA_DAYS   = 146097;
  localparam int unsigned ERA4_START = 4 * ERA_DAYS;
  localparam int unsigned ERA5_START = 5 * ERA_DAYS;
  localparam int unsigned ERA4_YEAR  = 1600;
  localparam int unsigned ERA5_YEAR  = 2000;

  // Reciprocals for the date chain
  localparam int unsigned Q1460_RECIP = 179;     // 2^16 / 365, applied to doe/4
  localparam int unsigned Q1460_SH    = 16;
  localparam int unsigned YOE_RECIP   = 183859;  // 2^26 / 365
  localparam int unsigned YOE_SH      = 26;
  localparam int unsigned MP_RECIP    = 428;     // 2^16 / 153
  localparam int unsigned MP_SH       = 16;

  // Reciprocals for the time of day (divide by 15 after a shift by 2)
  localparam int unsigned MIN_RECIP   = 2184;    // 2^15 / 15
  localparam int unsigned MIN_SH      = 15;
  localparam int unsigned HOUR_RECIP  = 546;     // 2^13 / 15
  localparam int unsigned HOUR_SH     = 13;

  localparam int unsigned WDAY_OF_EPOCH = 6;     // 2000-01-01 was a Saturday

  // Pipeline depths
  localparam int unsigned FRONT_STAGES = 3;
  localparam int unsigned CIV_STAGES   = 9;
  localparam int unsigned TOD_STAGES   = 4;
  localparam int unsigned PIPE_STAGES  = FRONT_STAGES + CIV_STAGES;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DOM_W-1:0]   day_of_month;
  } date_t;

  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
  } tod_t;

  // First day of a March-based month within its year: (153 * mp + 2) / 5
  function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
    logic [DOY_W-1:0] ofs;
    unique case (mp)
      4'd0:    ofs = 9'd0;
      4'd1:    ofs = 9'd31;
      4'd2:    ofs = 9'd61;
      4'd3:    ofs = 9'd92;
      4'd4:    ofs = 9'd122;
      4'd5:    ofs = 9'd153;
      4'd6:    ofs = 9'd184;
      4'd7:    ofs = 9'd214;
      4'd8:    ofs = 9'd245;
      4'd9:    ofs = 9'd275;
      4'd10:   ofs = 9'd306;
      4'd11:   ofs = 9'd337;
      default: ofs = 9'd0;
    endcase
    return ofs;
  endfunction

endpackage

### rtl/esdt_in_if.sv
interface esdt_in_if import esdt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SECS_W-1:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

### rtl/esdt_out_if.sv
interface esdt_out_if import esdt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0] month;
  logic [DOM_W-1:0]   day_of_month;
  logic [HOUR_W-1:0]  hour;
  logic [MIN_W-1:0]   minute;
  logic [SEC_W-1:0]   second;
  logic [WDAY_W-1:0]  weekday;

  modport source (output valid, output year, output month, output day_of_month,
                  output hour, output minute, output second, output weekday,
                  input ready);
  modport sink   (input valid, input year, input month, input day_of_month,
                  input hour, input minute, input second, input weekday,
                  output ready);
endinterface

### rtl/esdt_tod.sv
module esdt_tod import esdt_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [SOD_W-1:0] sod_i,
  output tod_t             tod_o
);

  localparam int unsigned MCNT_W = 11;  // minute of the day, < 1440
  localparam int unsigned T1_PW  = (SOD_W - 2) + 12;
  localparam int unsigned T3_PW  = (MCNT_W - 2) + 10;

  // T1: estimate minute of day = (sod / 4) / 15
  logic [T1_PW-1:0]  t1_prod;
  logic [MCNT_W-1:0] t1_est_d, t1_est_q;
  logic [SOD_W-1:0]  t1_sod_q;

  // T2: correct, split off the second
  logic [SOD_W-1:0]  t2_rem;
  logic              t2_wrap;
  logic [MCNT_W-1:0] t2_mcnt_d, t2_mcnt_q;
  logic [SEC_W-1:0]  t2_sec_d, t2_sec_q;

  // T3: estimate hour = (mcnt / 4) / 15
  logic [T3_PW-1:0]  t3_prod;
  logic [HOUR_W-1:0] t3_hest_d, t3_hest_q;
  logic [MCNT_W-1:0] t3_mcnt_q;
  logic [SEC_W-1:0]  t3_sec_q;

  // T4: correct, split off the minute
  logic [MCNT_W-1:0] t4_rem;
  logic              t4_wrap;
  tod_t              t4_tod_d, t4_tod_q;

  always_comb begin
    t1_prod  = T1_PW'(sod_i[SOD_W-1:2]) * T1_PW'(MIN_RECIP);
    t1_est_d = t1_prod[MIN_SH +: MCNT_W];

    t2_rem    = t1_sod_q - SOD_W'(t1_est_q) * SOD_W'(60);
    t2_wrap   = t2_rem >= SOD_W'(60);
    t2_mcnt_d = t1_est_q + MCNT_W'(t2_wrap);
    t2_sec_d  = t2_wrap ? SEC_W'(t2_rem - SOD_W'(60)) : SEC_W'(t2_rem);

    t3_prod   = T3_PW'(t2_mcnt_q[MCNT_W-1:2]) * T3_PW'(HOUR_RECIP);
    t3_hest_d = t3_prod[HOUR_SH +: HOUR_W];

    t4_rem          = t3_mcnt_q - MCNT_W'(t3_hest_q) * MCNT_W'(60);
    t4_wrap         = t4_rem >= MCNT_W'(60);
    t4_tod_d.hour   = t3_hest_q + HOUR_W'(t4_wrap);
    t4_tod_d.minute = t4_wrap ? MIN_W'(t4_rem - MCNT_W'(60)) : MIN_W'(t4_rem);
    t4_tod_d.second = t3_sec_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_est_q  <= t1_est_d;
      t1_sod_q  <= sod_i;
      t2_mcnt_q <= t2_mcnt_d;
      t2_sec_q  <= t2_sec_d;
      t3_hest_q <= t3_hest_d;
      t3_mcnt_q <= t2_mcnt_q;
      t3_sec_q  <= t2_sec_q;
      t4_tod_q  <= t4_tod_d;
    end
  end

  assign tod_o = t4_tod_q;

endmodule

### rtl/esdt_civil.sv
module esdt_civil import esdt_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [DAYS_W-1:0] days_i,
  output date_t             date_o
);

  localparam int unsigned Q_W   = DOE_W - 2;
  localparam int unsigned S2_PW = Q_W + 8;
  localparam int unsigned S4_PW = 2 * DOE_W;
  localparam int unsigned X5_W  = 11;   // 5 * doy + 2 < 2048
  localparam int unsigned S7_PW = X5_W + 9;

  // S1: day number, era (4 or 5 over this input range), day of era
  logic [Z_W-1:0]   s1_z;
  logic             s1_era5_d, s1_era5_q;
  logic [DOE_W-1:0] s1_doe_d, s1_doe_q;

  // S2: doe / 1460 estimate, doe / 36524, last day of era
  logic [S2_PW-1:0] s2_prod;
  logic [7:0]       s2_est_d, s2_est_q;
  logic [2:0]       s2_c_d, s2_c_q;
  logic             s2_last_d, s2_last_q;
  logic [DOE_W-1:0] s2_doe_q;
  logic             s2_era5_q;

  // S3: corrected doe / 1460, leap-adjusted day count
  logic [Q_W-1:0]   s3_rem;
  logic [7:0]       s3_q1460;
  logic [DOE_W-1:0] s3_a_d, s3_a_q;
  logic [DOE_W-1:0] s3_doe_q;
  logic             s3_era5_q;

  // S4: year of era estimate
  logic [S4_PW-1:0] s4_prod;
  logic [YOE_W-1:0] s4_yest_d, s4_yest_q;
  logic [DOE_W-1:0] s4_a_q, s4_doe_q;
  logic             s4_era5_q;

  // S5: corrected year of era
  logic [DOE_W-1:0] s5_rem;
  logic [YOE_W-1:0] s5_yoe_d, s5_yoe_q;
  logic [DOE_W-1:0] s5_doe_q;
  logic             s5_era5_q;

  // S6: day of year
  logic [1:0]       s6_cent;
  logic [DOE_W-1:0] s6_base;
  logic [DOY_W-1:0] s6_doy_d, s6_doy_q;
  logic [YOE_W-1:0] s6_yoe_q;
  logic             s6_era5_q;

  // S7: month estimate
  logic [X5_W-1:0]  s7_x_d, s7_x_q;
  logic [S7_PW-1:0] s7_prod;
  logic [MP_W-1:0]  s7_mest_d, s7_mest_q;
  logic [DOY_W-1:0] s7_doy_q;
  logic [YOE_W-1:0] s7_yoe_q;
  logic             s7_era5_q;

  // S8: corrected month
  logic [X5_W-1:0]  s8_rem;
  logic [MP_W-1:0]  s8_mp_d, s8_mp_q;
  logic [DOY_W-1:0] s8_doy_q;
  logic [YOE_W-1:0] s8_yoe_q;
  logic             s8_era5_q;

  // S9: calendar fields
  logic             s9_jan_feb;
  date_t            s9_date_d, s9_date_q;

  always_comb begin
    s1_z      = Z_W'(days_i) + Z_W'(Z_OFFSET);
    s1_era5_d = s1_z >= Z_W'(ERA5_START);
    s1_doe_d  = DOE_W'(s1_z - (s1_era5_d ? Z_W'(ERA5_START) : Z_W'(ERA4_START)));

    s2_prod   = S2_PW'(s1_doe_q[DOE_W-1:2]) * S2_PW'(Q1460_RECIP);
    s2_est_d  = s2_prod[Q1460_SH +: 8];
    s2_c_d    = 3'(s1_doe_q >= DOE_W'(36524)) + 3'(s1_doe_q >= DOE_W'(73048))
              + 3'(s1_doe_q >= DOE_W'(109572)) + 3'(s1_doe_q >= DOE_W'(146096));
    s2_last_d = s1_doe_q == DOE_W'(146096);

    s3_rem   = s2_doe_q[DOE_W-1:2] - Q_W'(s2_est_q) * Q_W'(365);
    s3_q1460 = s2_est_q + 8'(s3_rem >= Q_W'(365));
    s3_a_d   = s2_doe_q - DOE_W'(s3_q1460) + DOE_W'(s2_c_q) - DOE_W'(s2_last_q);

    s4_prod   = S4_PW'(s3_a_q) * S4_PW'(YOE_RECIP);
    s4_yest_d = s4_prod[YOE_SH +: YOE_W];

    s5_rem   = s4_a_q - DOE_W'(s4_yest_q) * DOE_W'(365);
    s5_yoe_d = s4_yest_q + YOE_W'(s5_rem >= DOE_W'(365));

    s6_cent  = 2'(s5_yoe_q >= YOE_W'(100)) + 2'(s5_yoe_q >= YOE_W'(200))
             + 2'(s5_yoe_q >= YOE_W'(300));
    s6_base  = DOE_W'(s5_yoe_q) * DOE_W'(365) + DOE_W'(s5_yoe_q[YOE_W-1:2])
             - DOE_W'(s6_cent);
    s6_doy_d = DOY_W'(s5_doe_q - s6_base);

    s7_x_d    = X5_W'(s6_doy_q) * X5_W'(5) + X5_W'(2);
    s7_prod   = S7_PW'(s7_x_d) * S7_PW'(MP_RECIP);
    s7_mest_d = s7_prod[MP_SH +: MP_W];

    s8_rem  = s7_x_q - X5_W'(s7_mest_q) * X5_W'(153);
    s8_mp_d = s7_mest_q + MP_W'(s8_rem >= X5_W'(153));

    // March-based months 10 and 11 are January and February of the next year
    s9_jan_feb             = s8_mp_q >= MP_W'(10);
    s9_date_d.day_of_month = DOM_W'(s8_doy_q - month_start(s8_mp_q) + DOY_W'(1));
    s9_date_d.month        = s9_jan_feb ? s8_mp_q - MP_W'(9) : s8_mp_q + MP_W'(3);
    s9_date_d.year         = YEAR_W'(s8_yoe_q)
                           + (s8_era5_q ? YEAR_W'(ERA5_YEAR) : YEAR_W'(ERA4_YEAR))
                           + YEAR_W'(s9_jan_feb);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_era5_q <= s1_era5_d;
      s1_doe_q  <= s1_doe_d;

      s2_est_q  <= s2_est_d;
      s2_c_q    <= s2_c_d;
      s2_last_q <= s2_last_d;
      s2_doe_q  <= s1_doe_q;
      s2_era5_q <= s1_era5_q;

      s3_a_q    <= s3_a_d;
      s3_doe_q  <= s2_doe_q;
      s3_era5_q <= s2_era5_q;

      s4_yest_q <= s4_yest_d;
      s4_a_q    <= s3_a_q;
      s4_doe_q  <= s3_doe_q;
      s4_era5_q <= s3_era5_q;

      s5_yoe_q  <= s5_yoe_d;
      s5_doe_q  <= s4_doe_q;
      s5_era5_q <= s4_era5_q;

      s6_doy_q  <= s6_doy_d;
      s6_yoe_q  <= s5_yoe_q;
      s6_era5_q <= s5_era5_q;

      s7_x_q    <= s7_x_d;
      s7_mest_q <= s7_mest_d;
      s7_doy_q  <= s6_doy_q;
      s7_yoe_q  <= s6_yoe_q;
      s7_era5_q <= s6_era5_q;

      s8_mp_q   <= s8_mp_d;
      s8_doy_q  <= s7_doy_q;
      s8_yoe_q  <= s7_yoe_q;
      s8_era5_q <= s7_era5_q;

      s9_date_q <= s9_date_d;
    end
  end

  assign date_o = s9_date_q;

endmodule

### rtl/epoch_seconds_to_datetime_core.sv
// Converts a 32-bit count of seconds since 2000-01-01 00:00:00 into proleptic
// Gregorian year, month, day, hour, minute, second and weekday (0 = Sunday).
// Every input value is valid; the last one falls in 2136. The block is a
// 12-stage pipeline that takes one request per clock when the output is not
// held off. The whole pipe advances together on a single enable, so a stall
// at the output freezes every stage and input ready falls with it; no request
// is dropped or repeated. The stages follow the constant-divisor chain: days
// and second of day, then day of era, year of era and month, each divide done
// as a reciprocal multiply followed by a one-step correction in a later stage.
module epoch_seconds_to_datetime_core import esdt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  esdt_in_if.sink    req_i,
  esdt_out_if.source res_o
);

  localparam int unsigned Q1_W   = SECS_W - DAY_SH;
  localparam int unsigned A_PW   = Q1_W + DAYS_W;
  localparam int unsigned REM_W  = 11;  // remainder before correction, < 2 * 675
  localparam int unsigned WS_W   = 6;   // sum of octal digits of the day count plus the epoch weekday
  localparam int unsigned TOD_DLY = CIV_STAGES - TOD_STAGES;

  logic en;
  logic [PIPE_STAGES-1:0] vld_q;

  // A: reciprocal multiply for days
  logic [A_PW-1:0]   a_prod_d, a_prod_q;
  logic [SECS_W-1:0] a_secs_q;

  // B: day estimate and remainder
  logic [DAYS_W-1:0]  b_dq_d, b_dq_q;
  logic [REM_W-1:0]   b_rem_d, b_rem_q;
  logic [DAY_SH-1:0]  b_low_q;

  // C: corrected days and second of day
  logic               c_wrap;
  logic [REM_W-1:0]   c_rem;
  logic [DAYS_W-1:0]  c_days_d, c_days_q;
  logic [SOD_W-1:0]   c_sod_d, c_sod_q;

  // Weekday, computed alongside the first date stage
  logic [DAYS_W-1:0]  w_val;
  logic [WS_W-1:0]    w_sum;
  logic [3:0]         w_fold;
  logic [WDAY_W-1:0]  w_day;
  logic [WDAY_W-1:0]  wday_q [CIV_STAGES];

  date_t date;
  tod_t  tod;
  tod_t  tod_q [TOD_DLY];

  assign en          = !vld_q[PIPE_STAGES-1] || res_o.ready;
  assign req_i.ready = en;

  always_comb begin
    a_prod_d = A_PW'(req_i.epoch_seconds[SECS_W-1:DAY_SH]) * A_PW'(DAY_RECIP);

    b_dq_d  = a_prod_q[DAY_RECIP_SH +: DAYS_W];
    b_rem_d = REM_W'(a_secs_q[SECS_W-1:DAY_SH] - Q1_W'(b_dq_d) * Q1_W'(DAY_DIV));

    c_wrap   = b_rem_q >= REM_W'(DAY_DIV);
    c_rem    = c_wrap ? b_rem_q - REM_W'(DAY_DIV) : b_rem_q;
    c_days_d = b_dq_q + DAYS_W'(c_wrap);
    c_sod_d  = {c_rem[SOD_W-DAY_SH-1:0], b_low_q};

    // 8 = 1 mod 7, so summing octal digits keeps the residue
    w_val  = c_days_q + DAYS_W'(WDAY_OF_EPOCH);
    w_sum  = WS_W'(w_val[2:0]) + WS_W'(w_val[5:3]) + WS_W'(w_val[8:6])
           + WS_W'(w_val[11:9]) + WS_W'(w_val[14:12]) + WS_W'(w_val[15]);
    w_fold = 4'(w_sum[5:3]) + 4'(w_sum[2:0]);
    w_day  = (w_fold >= 4'd7) ? WDAY_W'(w_fold - 4'd7) : WDAY_W'(w_fold);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_STAGES-2:0], req_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_prod_q <= a_prod_d;
      a_secs_q <= req_i.epoch_seconds;
      b_dq_q   <= b_dq_d;
      b_rem_q  <= b_rem_d;
      b_low_q  <= a_secs_q[DAY_SH-1:0];
      c_days_q <= c_days_d;
      c_sod_q  <= c_sod_d;
      wday_q[0] <= w_day;
      for (int i = 1; i < CIV_STAGES; i++) begin
        wday_q[i] <= wday_q[i-1];
      end
      tod_q[0] <= tod;
      for (int i = 1; i < TOD_DLY; i++) begin
        tod_q[i] <= tod_q[i-1];
      end
    end
  end

  esdt_civil u_civil (
    .clk_i  (clk_i),
    .en_i   (en),
    .days_i (c_days_q),
    .date_o (date)
  );

  esdt_tod u_tod (
    .clk_i (clk_i),
    .en_i  (en),
    .sod_i (c_sod_q),
    .tod_o (tod)
  );

  assign res_o.valid        = vld_q[PIPE_STAGES-1];
  assign res_o.year         = date.year;
  assign res_o.month        = date.month;
  assign res_o.day_of_month = date.day_of_month;
  assign res_o.hour         = tod_q[TOD_DLY-1].hour;
  assign res_o.minute       = tod_q[TOD_DLY-1].minute;
  assign res_o.second       = tod_q[TOD_DLY-1].second;
  assign res_o.weekday      = wday_q[CIV_STAGES-1];

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> vld_q[0])
    else $error("accepted request did not enter the pipeline");

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved while stalled");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.year >= YEAR_W'(2000) && res_o.year <= YEAR_W'(2136)
                     && res_o.month >= MONTH_W'(1) && res_o.month <= MONTH_W'(12)
                     && res_o.day_of_month >= DOM_W'(1)))
    else $error("date field out of range");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.hour < HOUR_W'(24) && res_o.minute < MIN_W'(60)
                     && res_o.second < SEC_W'(60) && res_o.weekday < WDAY_W'(7)))
    else $error("time field out of range");

endmodule

### sim/testbench.sv
module testbench import esdt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SECS_PER_DAY    = 86400;
  localparam int unsigned SECS_PER_HOUR   = 3600;
  localparam int unsigned SECS_PER_MIN    = 60;
  localparam int unsigned EPOCH_DAY_NUM   = 730425;  // 2000-01-01 counted from 0000-03-01
  localparam int unsigned DAYS_PER_ERA    = 146097;
  localparam int unsigned EPOCH_WEEKDAY   = 6;       // Saturday
  localparam int unsigned LAST_DAY        = 49709;   // last whole day below 2^32 seconds
  localparam int unsigned DRAIN_CYCLES    = 20;
  localparam int unsigned CYCLE_LIMIT     = 400000;

  typedef struct packed {
    date_t             date;
    tod_t              tod;
    logic [WDAY_W-1:0] weekday;
  } datetime_t;

  class datetime_scoreboard;
    datetime_t pending_datetimes[$];
    int unsigned errors;

    function automatic datetime_t to_civil_datetime(input logic [SECS_W-1:0] secs);
      int unsigned days, sod, z, era, doe, yoe, doy, mp, mon;
      datetime_t dt;
      days = secs / SECS_PER_DAY;
      sod  = secs % SECS_PER_DAY;
      z    = days + EPOCH_DAY_NUM;
      era  = z / DAYS_PER_ERA;
      doe  = z - era * DAYS_PER_ERA;
      yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp   = (5 * doy + 2) / 153;
      mon  = (mp < 10) ? mp + 3 : mp - 9;
      dt.date.year         = YEAR_W'(yoe + era * 400 + ((mon <= 2) ? 1 : 0));
      dt.date.month        = MONTH_W'(mon);
      dt.date.day_of_month = DOM_W'(doy - (153 * mp + 2) / 5 + 1);
      dt.tod.hour          = HOUR_W'(sod / SECS_PER_HOUR);
      dt.tod.minute        = MIN_W'((sod / SECS_PER_MIN) % 60);
      dt.tod.second        = SEC_W'(sod % SECS_PER_MIN);
      dt.weekday           = WDAY_W'((days + EPOCH_WEEKDAY) % 7);
      return dt;
    endfunction

    function void note_request(input logic [SECS_W-1:0] secs);
      pending_datetimes.push_back(to_civil_datetime(secs));
    endfunction

    function void compare_field(input string name, input int unsigned exp_val,
                                input int unsigned act_val);
      if (exp_val != act_val) begin
        $error("%s: expected %0d, got %0d", name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_result(input datetime_t act);
      datetime_t exp_dt;
      if (pending_datetimes.size() == 0) begin
        $error("result with no request outstanding: %p", act);
        errors++;
        return;
      end
      exp_dt = pending_datetimes.pop_front();
      compare_field("year", exp_dt.date.year, act.date.year);
      compare_field("month", exp_dt.date.month, act.date.month);
      compare_field("day_of_month", exp_dt.date.day_of_month, act.date.day_of_month);
      compare_field("hour", exp_dt.tod.hour, act.tod.hour);
      compare_field("minute", exp_dt.tod.minute, act.tod.minute);
      compare_field("second", exp_dt.tod.second, act.tod.second);
      compare_field("weekday", exp_dt.weekday, act.weekday);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned cycle_count;
  datetime_scoreboard sb;

  esdt_in_if  req_if ();
  esdt_out_if res_if ();

  epoch_seconds_to_datetime_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if.sink),
    .res_o  (res_if.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk) begin
    res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    datetime_t act;
    if (rst_n && res_if.valid && res_if.ready) begin
      act.date.year         = res_if.year;
      act.date.month        = res_if.month;
      act.date.day_of_month = res_if.day_of_month;
      act.tod.hour          = res_if.hour;
      act.tod.minute        = res_if.minute;
      act.tod.second        = res_if.second;
      act.weekday           = res_if.weekday;
      sb.check_result(act);
    end
  end

  task automatic send_seconds(input logic [SECS_W-1:0] secs);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      req_if.valid <= 1'b0;
    end
    @(negedge clk);
    req_if.valid         <= 1'b1;
    req_if.epoch_seconds <= secs;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(secs);
  endtask

  // lower the request and hold off until the pipe has emptied
  task automatic wait_for_drain();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (sb.pending_datetimes.size() != 0) @(posedge clk);
  endtask

  task automatic send_random(input int unsigned count);
    int unsigned sel, day, yr, leaps;
    logic [SECS_W-1:0] secs;
    repeat (count) begin
      sel = $urandom_range(9);
      if (sel < 4) begin
        secs = $urandom;
      end else if (sel < 6) begin
        // either side of midnight
        day  = $urandom_range(LAST_DAY);
        secs = day * SECS_PER_DAY + ($urandom_range(1) ? $urandom_range(2)
                                     : SECS_PER_DAY - 1 - $urandom_range(2));
      end else if (sel < 8) begin
        // 28 February to 1 March of a random year (to 2 March in a common year)
        yr    = $urandom_range(2135, 2000);
        leaps = ((yr - 1) / 4 - 1999 / 4) - ((yr - 1) / 100 - 1999 / 100)
                + ((yr - 1) / 400 - 1999 / 400);
        day   = 365 * (yr - 2000) + leaps + 58 + $urandom_range(2);
        secs  = day * SECS_PER_DAY + $urandom_range(SECS_PER_DAY - 1);
      end else if (sel == 8) begin
        secs = 32'hFFFF_FFFF - $urandom_range(200000);
      end else begin
        secs = $urandom_range(100000);
      end
      send_seconds(secs);
    end
  endtask

  initial begin
    logic [SECS_W-1:0] corner_seconds[$];
    corner_seconds = '{
      32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
      32'd2678399,     // 2000-01-31 23:59:59
      32'd5097600,     // 2000-02-29, leap century
      32'd5184000,     // 2000-03-01
      32'd31622399,    // 2000-12-31 23:59:59
      32'd31622400,    // 2001-01-01
      32'd3160857599,  // 2100-02-28 23:59:59, century without leap day
      32'd3160857600,  // 2100-03-01
      32'd3373401600,  // 2106-11-25
      32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
      32'hFFFF_FFFE, 32'hFFFF_FFFF
    };
    sb = new;
    rst_n                = 1'b0;
    send_idle_pct        = 0;
    recv_idle_pct        = 0;
    req_if.valid         = 1'b0;
    req_if.epoch_seconds = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (corner_seconds[i]) send_seconds(corner_seconds[i]);
    wait_for_drain();

    send_idle_pct = 35;
    recv_idle_pct = 76;
    send_random(630);
    wait_for_drain();

    send_idle_pct = 76;
    recv_idle_pct = 35;
    send_random(630);
    wait_for_drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(620);
    wait_for_drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_datetimes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### epoch_seconds_to_datetime_core.f
rtl/esdt_pkg.sv
rtl/esdt_in_if.sv
rtl/esdt_out_if.sv
rtl/esdt_tod.sv
rtl/esdt_civil.sv
rtl/epoch_seconds_to_datetime_core.sv
sim/testbench.sv
